/* src/assert_macros.svh */
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IMU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define IMU_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define IMU_ASSERT(label, clk, rst_n, prop, msg)

`define IMU_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* src/imu_cf_pkg.sv */
// Constants, widths and the arctangent table of the attitude filter.
package imu_cf_pkg;

  localparam int AtanIdxW = 5;
  localparam int VecW     = 36;
  localparam int ZW       = 34;
  localparam int AngW     = 33;
  localparam int SumW     = 34;
  localparam int AccW     = 44;
  localparam int MulAW    = 35;
  localparam int MulBW    = 17;
  localparam int ProdW    = MulAW + MulBW;
  localparam int OutW     = 17;
  localparam int FracDrop = 16;
  localparam int BlendSh  = 8;

  localparam logic signed [ZW-1:0] Deg90  = 34'sd1509949440;
  localparam logic signed [ZW-1:0] Deg180 = 34'sd3019898880;
  localparam logic signed [ZW-1:0] Deg360 = 34'sd6039797760;

  localparam logic [8:0]  WeightFull  = 9'd256;
  localparam logic [8:0]  WeightReset = 9'd230;
  localparam logic [15:0] GainReset   = 16'd5117;

  localparam logic RegBlend = 1'b0;
  localparam logic RegGain  = 1'b1;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [AtanIdxW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd754974720;
      5'd1:    v = 34'sd445687602;
      5'd2:    v = 34'sd235489088;
      5'd3:    v = 34'sd119537938;
      5'd4:    v = 34'sd60000934;
      5'd5:    v = 34'sd30029717;
      5'd6:    v = 34'sd15018523;
      5'd7:    v = 34'sd7509720;
      5'd8:    v = 34'sd3754917;
      5'd9:    v = 34'sd1877466;
      5'd10:   v = 34'sd938734;
      5'd11:   v = 34'sd469367;
      5'd12:   v = 34'sd234684;
      5'd13:   v = 34'sd117342;
      5'd14:   v = 34'sd58672;
      5'd15:   v = 34'sd29336;
      5'd16:   v = 34'sd14668;
      5'd17:   v = 34'sd7334;
      5'd18:   v = 34'sd3667;
      5'd19:   v = 34'sd1833;
      5'd20:   v = 34'sd917;
      5'd21:   v = 34'sd458;
      5'd22:   v = 34'sd229;
      5'd23:   v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/imu_attitude_complementary_filter_unit.sv */
// Top level of the IMU attitude complementary filter.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one raw six-axis sample per
//   transaction plus a clear flag that zeroes roll, pitch and yaw first.
//   Output channel (out_valid_o/out_ready_i) returns roll, pitch and yaw in
//   1/256 degree, one transaction per sample.
//   A shared CORDIC vectoring stage runs CORDIC_STEPS iterations for roll and
//   then for pitch; a shared 35x17 multiplier then does nine blend steps.
//   in_ready_o rises together with out_valid_o, so the block takes no new
//   sample until the previous result has been loaded into the output register.
//   The result sits in an output register; a new sample is accepted while it
//   waits. If the receiver stalls, the next result holds in the final
//   sequencer state until the output register frees up.
//   Reset zeroes the angles, sets blend weight to 230 and gain to 5117.
//   APB: register 0 (byte 0) blend weight, register 1 (byte 4) gyro gain.
//   Write registers only while the block is idle.
`include "assert_macros.svh"

module imu_attitude_complementary_filter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic signed [15:0]  rate_x_i,
  input  logic signed [15:0]  rate_y_i,
  input  logic signed [15:0]  rate_z_i,
  input  logic                clear_angles_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  roll_deg_o,
  output logic signed [16:0]  pitch_deg_o,
  output logic signed [16:0]  yaw_deg_o
);

  localparam int CntW = $clog2(CORDIC_STEPS);
  localparam int IdxW = imu_cf_pkg::AtanIdxW;
  localparam int VecW = imu_cf_pkg::VecW;
  localparam int ZW   = imu_cf_pkg::ZW;
  localparam int AngW = imu_cf_pkg::AngW;
  localparam int SumW = imu_cf_pkg::SumW;
  localparam int AccW = imu_cf_pkg::AccW;
  localparam int MulAW = imu_cf_pkg::MulAW;
  localparam int MulBW = imu_cf_pkg::MulBW;
  localparam int ProdW = imu_cf_pkg::ProdW;
  localparam int OutW = imu_cf_pkg::OutW;
  localparam logic [CntW-1:0] LastIter = CntW'(CORDIC_STEPS - 1);

  localparam logic [3:0] BsRollSum  = 4'd0;
  localparam logic [3:0] BsRollW    = 4'd1;
  localparam logic [3:0] BsRollAcc  = 4'd2;
  localparam logic [3:0] BsRollSat  = 4'd3;
  localparam logic [3:0] BsPitchSum = 4'd4;
  localparam logic [3:0] BsPitchW   = 4'd5;
  localparam logic [3:0] BsPitchAcc = 4'd6;
  localparam logic [3:0] BsPitchSat = 4'd7;
  localparam logic [3:0] BsYaw      = 4'd8;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROLL  = 5'b00010,
    S_PITCH = 5'b00100,
    S_BLEND = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [8:0]  weight_q;
  logic [15:0] gain_q;

  logic signed [15:0] ax_q, az_q, rx_q, ry_q, rz_q;
  logic signed [VecW-1:0] x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic                   zero_q;
  logic [CntW-1:0]        cnt_q;
  logic signed [ZW-1:0]   roll_acc_q, pitch_acc_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [AccW-1:0] acc_q;
  logic [3:0]             bstep_q;
  logic signed [AngW-1:0] roll_q, pitch_q, yaw_q;
  logic signed [OutW-1:0] roll_out_q, pitch_out_q, yaw_out_q;
  logic                   out_valid_q;

  logic in_fire, emit_load, cfg_write, last_iter, blend_done;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign emit_load  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign last_iter  = (cnt_q == LastIter);
  assign blend_done = (bstep_q == BsYaw);

  // APB register file
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      imu_cf_pkg::RegBlend: prdata = {23'd0, weight_q};
      imu_cf_pkg::RegGain:  prdata = {16'd0, gain_q};
      default:              prdata = '0;
    endcase
  end

  // CORDIC load: pick operands and turn into the right half plane
  logic signed [16:0]     ld_x, ld_y;
  logic signed [VecW-1:0] vx, vy, lx, ly;
  logic signed [ZW-1:0]   lz;
  logic                   ld_zero;

  always_comb begin
    if (state_q == S_IDLE) begin
      ld_x = {accel_z_i[15], accel_z_i};
      ld_y = {accel_y_i[15], accel_y_i};
    end else begin
      ld_x = {az_q[15], az_q};
      ld_y = -{ax_q[15], ax_q};
    end
    vx = {{(VecW-33){ld_x[16]}}, ld_x, 16'd0};
    vy = {{(VecW-33){ld_y[16]}}, ld_y, 16'd0};
    ld_zero = (ld_x == '0) && (ld_y == '0);
    if (ld_x < 0) begin
      if (ld_y >= 0) begin
        lx = vy;
        ly = -vx;
        lz = imu_cf_pkg::Deg90;
      end else begin
        lx = -vy;
        ly = vx;
        lz = -imu_cf_pkg::Deg90;
      end
    end else begin
      lx = vx;
      ly = vy;
      lz = '0;
    end
  end

  // CORDIC iteration
  logic signed [VecW-1:0] dx, dy, xn, yn;
  logic signed [ZW-1:0]   zn, atan_v, z_fin;

  always_comb begin
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    atan_v = imu_cf_pkg::atan_lut(IdxW'(cnt_q));
    if (y_q > 0) begin
      xn = x_q + dx;
      yn = y_q - dy;
      zn = z_q + atan_v;
    end else begin
      xn = x_q - dx;
      yn = y_q + dy;
      zn = z_q - atan_v;
    end
    z_fin = zero_q ? '0 : zn;
  end

  // Shared multiplier and blend arithmetic
  logic [8:0]              w_eff, w_inv;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AngW-1:0]  ang_sel;
  logic signed [SumW-1:0]  sum_d;
  logic signed [AccW-1:0]  acc_sum, acc_sh, sat_hi, sat_lo;
  logic signed [AngW-1:0]  sat_v;
  logic signed [ZW-1:0]    ysum, ywrap;

  always_comb begin
    w_eff = (weight_q > imu_cf_pkg::WeightFull) ? imu_cf_pkg::WeightFull : weight_q;
    w_inv = imu_cf_pkg::WeightFull - w_eff;
    case (bstep_q)
      BsRollSum: begin
        mul_a = {{(MulAW-16){rx_q[15]}}, rx_q};
        mul_b = {1'b0, gain_q};
      end
      BsRollW, BsPitchW: begin
        mul_a = {{(MulAW-SumW){sum_q[SumW-1]}}, sum_q};
        mul_b = {{(MulBW-9){1'b0}}, w_eff};
      end
      BsRollAcc: begin
        mul_a = {{(MulAW-ZW){roll_acc_q[ZW-1]}}, roll_acc_q};
        mul_b = {{(MulBW-9){1'b0}}, w_inv};
      end
      BsPitchSum: begin
        mul_a = {{(MulAW-16){ry_q[15]}}, ry_q};
        mul_b = {1'b0, gain_q};
      end
      BsPitchAcc: begin
        mul_a = {{(MulAW-ZW){pitch_acc_q[ZW-1]}}, pitch_acc_q};
        mul_b = {{(MulBW-9){1'b0}}, w_inv};
      end
      BsYaw: begin
        mul_a = {{(MulAW-16){rz_q[15]}}, rz_q};
        mul_b = {1'b0, gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;

    ang_sel = (bstep_q == BsRollSum) ? roll_q : pitch_q;
    sum_d   = {{(SumW-AngW){ang_sel[AngW-1]}}, ang_sel} + prod[SumW-1:0];
    acc_sum = acc_q + prod[AccW-1:0];

    acc_sh = acc_q >>> imu_cf_pkg::BlendSh;
    sat_hi = {{(AccW-ZW){imu_cf_pkg::Deg180[ZW-1]}}, imu_cf_pkg::Deg180};
    sat_lo = -sat_hi;
    if (acc_sh > sat_hi) begin
      sat_v = imu_cf_pkg::Deg180[AngW-1:0];
    end else if (acc_sh < sat_lo) begin
      sat_v = sat_lo[AngW-1:0];
    end else begin
      sat_v = acc_sh[AngW-1:0];
    end

    ysum = {{(ZW-AngW){yaw_q[AngW-1]}}, yaw_q} + prod[ZW-1:0];
    if (ysum >= imu_cf_pkg::Deg180) begin
      ywrap = ysum - imu_cf_pkg::Deg360;
    end else if (ysum < -imu_cf_pkg::Deg180) begin
      ywrap = ysum + imu_cf_pkg::Deg360;
    end else begin
      ywrap = ysum;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_ROLL;
      S_ROLL:  if (last_iter) state_d = S_PITCH;
      S_PITCH: if (last_iter) state_d = S_BLEND;
      S_BLEND: if (blend_done) state_d = S_EMIT;
      S_EMIT:  if (emit_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      weight_q    <= imu_cf_pkg::WeightReset;
      gain_q      <= imu_cf_pkg::GainReset;
      cnt_q       <= '0;
      bstep_q     <= BsRollSum;
      out_valid_q <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_write) begin
        unique case (paddr[2])
          imu_cf_pkg::RegBlend: weight_q <= pwdata[8:0];
          imu_cf_pkg::RegGain:  gain_q   <= pwdata[15:0];
          default:              weight_q <= weight_q;
        endcase
      end
      if (in_fire || ((state_q == S_ROLL) && last_iter)) begin
        cnt_q <= '0;
      end else if ((state_q == S_ROLL) || (state_q == S_PITCH)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if ((state_q == S_PITCH) && last_iter) begin
        bstep_q <= BsRollSum;
      end else if (state_q == S_BLEND) begin
        bstep_q <= bstep_q + 1'b1;
      end
      if (in_fire && clear_angles_i) begin
        roll_q  <= '0;
        pitch_q <= '0;
        yaw_q   <= '0;
      end else if (state_q == S_BLEND) begin
        case (bstep_q)
          BsRollSat:  roll_q  <= sat_v;
          BsPitchSat: pitch_q <= sat_v;
          BsYaw:      yaw_q   <= ywrap[AngW-1:0];
          default:    roll_q  <= roll_q;
        endcase
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= accel_x_i;
      az_q <= accel_z_i;
      rx_q <= rate_x_i;
      ry_q <= rate_y_i;
      rz_q <= rate_z_i;
    end
    if (in_fire || ((state_q == S_ROLL) && last_iter)) begin
      x_q    <= lx;
      y_q    <= ly;
      z_q    <= lz;
      zero_q <= ld_zero;
    end else if ((state_q == S_ROLL) || (state_q == S_PITCH)) begin
      x_q <= xn;
      y_q <= yn;
      z_q <= zn;
    end
    if ((state_q == S_ROLL) && last_iter) begin
      roll_acc_q <= z_fin;
    end
    if ((state_q == S_PITCH) && last_iter) begin
      pitch_acc_q <= z_fin;
    end
    if (state_q == S_BLEND) begin
      case (bstep_q)
        BsRollSum, BsPitchSum: sum_q <= sum_d;
        BsRollW, BsPitchW:     acc_q <= prod[AccW-1:0];
        BsRollAcc, BsPitchAcc: acc_q <= acc_sum;
        default:               acc_q <= acc_q;
      endcase
    end
    if (emit_load) begin
      roll_out_q  <= roll_q[AngW-1:imu_cf_pkg::FracDrop];
      pitch_out_q <= pitch_q[AngW-1:imu_cf_pkg::FracDrop];
      yaw_out_q   <= yaw_q[AngW-1:imu_cf_pkg::FracDrop];
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_deg_o  = roll_out_q;
  assign pitch_deg_o = pitch_out_q;
  assign yaw_deg_o   = yaw_out_q;

  logic signed [AngW-1:0] ang_lim;
  logic                   roll_in_range, yaw_in_range, emit_stall;

  assign ang_lim       = $signed(imu_cf_pkg::Deg180[AngW-1:0]);
  assign roll_in_range = (roll_q <= ang_lim) && (roll_q >= -ang_lim);
  assign yaw_in_range  = (yaw_q < ang_lim) && (yaw_q >= -ang_lim);
  assign emit_stall    = (state_q == S_EMIT) && out_valid_q && !out_ready_i;

  `IMU_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !in_ready_o, "ready after accept")
  `IMU_ASSERT(a_roll_sat, clk_i, rst_ni, roll_in_range, "roll out of range")
  `IMU_ASSERT(a_yaw_wrap, clk_i, rst_ni, yaw_in_range, "yaw out of range")
  `IMU_ASSERT(a_emit_hold, clk_i, rst_ni, emit_stall |=> (state_q == S_EMIT), "result dropped")

endmodule

/* verif/imu_attitude_complementary_filter_unit_tb.sv */
// Self-checking testbench for the IMU attitude complementary filter unit.
`timescale 1ns / 100ps

module imu_attitude_complementary_filter_unit_tb;

  localparam int CORDIC_STEPS = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_AT = 450;
  localparam int PRESSURE_CYCLES = 500;
  localparam logic [2:0] BLEND_ADDR = 3'd0;
  localparam logic [2:0] GAIN_ADDR = 3'd4;
  localparam longint DEG90 = 64'sd1509949440;
  localparam longint DEG180 = 64'sd3019898880;
  localparam longint DEG360 = 64'sd6039797760;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic               clr;
  } imu_item_t;

  typedef struct {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [16:0] yaw;
  } attitude_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic signed [15:0] rate_x_i = '0;
  logic signed [15:0] rate_y_i = '0;
  logic signed [15:0] rate_z_i = '0;
  logic clear_angles_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [16:0] roll_deg_o;
  logic signed [16:0] pitch_deg_o;
  logic signed [16:0] yaw_deg_o;

  imu_item_t item_queue[$];
  attitude_t attitude_queue[$];
  imu_item_t cur_item;
  longint atan_step [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58672, 29336, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };
  longint roll_state = 0;
  longint pitch_state = 0;
  longint yaw_state = 0;
  logic [8:0] cfg_weight = 9'd230;
  logic [15:0] cfg_gain = 16'd5117;
  bit idle_on = 1'b1;
  bit pressure_done = 1'b0;
  int in_count = 0;
  int fail_count = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  imu_attitude_complementary_filter_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .rate_x_i       (rate_x_i),
    .rate_y_i       (rate_y_i),
    .rate_z_i       (rate_z_i),
    .clear_angles_i (clear_angles_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .roll_deg_o     (roll_deg_o),
    .pitch_deg_o    (pitch_deg_o),
    .yaw_deg_o      (yaw_deg_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint tilt_atan2(input longint y_in, input longint x_in);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    if (x_in == 0 && y_in == 0) return 0;
    x = x_in * 65536;
    y = y_in * 65536;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x;
        x = y;
        y = -t;
        z = DEG90;
      end else begin
        t = x;
        x = -y;
        y = t;
        z = -DEG90;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end
    end
    return z;
  endfunction

  function automatic longint blend_angle(input longint angle, input longint gyro_step,
                                         input longint accel_angle, input longint w);
    longint v;
    v = (w * (angle + gyro_step) + (256 - w) * accel_angle) >>> 8;
    if (v > DEG180) v = DEG180;
    if (v < -DEG180) v = -DEG180;
    return v;
  endfunction

  task automatic predict_attitude(input imu_item_t s);
    longint gain;
    longint w;
    longint roll_acc;
    longint pitch_acc;
    attitude_t e;
    gain = longint'(cfg_gain);
    w = (cfg_weight > 9'd256) ? 256 : longint'(cfg_weight);
    if (s.clr) begin
      roll_state = 0;
      pitch_state = 0;
      yaw_state = 0;
    end
    roll_acc = tilt_atan2(longint'(s.ay), longint'(s.az));
    pitch_acc = tilt_atan2(-longint'(s.ax), longint'(s.az));
    roll_state = blend_angle(roll_state, longint'(s.gx) * gain, roll_acc, w);
    pitch_state = blend_angle(pitch_state, longint'(s.gy) * gain, pitch_acc, w);
    yaw_state = yaw_state + longint'(s.gz) * gain;
    if (yaw_state >= DEG180) yaw_state = yaw_state - DEG360;
    else if (yaw_state < -DEG180) yaw_state = yaw_state + DEG360;
    e.roll = 17'(roll_state >>> 16);
    e.pitch = 17'(pitch_state >>> 16);
    e.yaw = 17'(yaw_state >>> 16);
    attitude_queue.push_back(e);
  endtask

  task automatic check_attitude();
    attitude_t want;
    if (attitude_queue.size() == 0) begin
      $display("%0t unexpected result: expected none, got roll %0d pitch %0d yaw %0d",
               $time, roll_deg_o, pitch_deg_o, yaw_deg_o);
      fail_count++;
      return;
    end
    want = attitude_queue.pop_front();
    if (roll_deg_o !== want.roll) begin
      $display("%0t roll mismatch: expected %0d, got %0d", $time, want.roll, roll_deg_o);
      fail_count++;
    end
    if (pitch_deg_o !== want.pitch) begin
      $display("%0t pitch mismatch: expected %0d, got %0d", $time, want.pitch, pitch_deg_o);
      fail_count++;
    end
    if (yaw_deg_o !== want.yaw) begin
      $display("%0t yaw mismatch: expected %0d, got %0d", $time, want.yaw, yaw_deg_o);
      fail_count++;
    end
  endtask

  function automatic logic signed [15:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4, 5: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_item(input int ax, input int ay, input int az, input int gx,
                            input int gy, input int gz, input bit clr);
    imu_item_t s;
    s.ax = 16'(ax);
    s.ay = 16'(ay);
    s.az = 16'(az);
    s.gx = 16'(gx);
    s.gy = 16'(gy);
    s.gz = 16'(gz);
    s.clr = clr;
    item_queue.push_back(s);
  endtask

  task automatic queue_random(input int n);
    imu_item_t s;
    for (int k = 0; k < n; k++) begin
      s.ax = pick_count();
      s.ay = pick_count();
      s.az = pick_count();
      s.gx = pick_count();
      s.gy = pick_count();
      s.gz = pick_count();
      s.clr = ($urandom_range(0, 19) == 0);
      item_queue.push_back(s);
    end
  endtask

  task automatic wait_drained();
    while (item_queue.size() != 0 || in_valid_i || attitude_queue.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == BLEND_ADDR) cfg_weight = data[8:0];
    else cfg_gain = data[15:0];
  endtask

  task automatic run_phase(input int weight, input int gain, input int n, input bit idling);
    wait_drained();
    apb_write(BLEND_ADDR, 32'(weight));
    apb_write(GAIN_ADDR, 32'(gain));
    idle_on = idling;
    queue_random(n);
  endtask

  // Driver: present one transaction at a time, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_attitude(cur_item);
        in_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else if (item_queue.size() > 0) begin
          cur_item = item_queue.pop_front();
          in_valid_i <= 1'b1;
          accel_x_i <= cur_item.ax;
          accel_y_i <= cur_item.ay;
          accel_z_i <= cur_item.az;
          rate_x_i <= cur_item.gx;
          rate_y_i <= cur_item.gy;
          rate_z_i <= cur_item.gz;
          clear_angles_i <= cur_item.clr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results, throttle the output side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_attitude();
      if (!pressure_done && in_count >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("imu_attitude_complementary_filter_unit_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_item(0, 0, 0, 0, 0, 0, 1'b0);
    queue_item(0, 0, 16384, 10, -10, 5, 1'b0);
    queue_item(0, 16384, 0, 0, 0, 0, 1'b0);
    queue_item(0, -16384, 0, 0, 0, 0, 1'b0);
    queue_item(0, 100, -16384, 0, 0, 0, 1'b0);
    queue_item(0, 0, -16384, 0, 0, 0, 1'b0);
    queue_item(0, -100, -16384, 0, 0, 0, 1'b0);
    queue_item(-32768, -32768, -32768, 0, 0, 0, 1'b0);
    queue_item(32767, -32768, 32767, 0, 0, 0, 1'b0);
    queue_item(-32768, 32767, -32768, 32767, 32767, 32767, 1'b0);
    queue_item(32767, 32767, 32767, 32767, 32767, 32767, 1'b0);
    queue_item(-1, -1, -1, -32768, -32768, -32768, 1'b0);
    queue_item(-32768, 0, 0, -32768, -32768, -32768, 1'b0);
    queue_item(32767, 0, 0, 32767, -32768, 32767, 1'b0);
    queue_item(1234, -4321, 777, 300, -300, 20000, 1'b1);
    queue_item(0, 0, 0, -1, 1, -1, 1'b0);
    queue_item(-32768, -32768, 32767, -32768, 32767, -32768, 1'b1);
    queue_item(1, 1, 1, 1, 1, 1, 1'b0);
    queue_item(-21846, 21845, -21846, 21845, -21846, 21845, 1'b0);
    queue_item(21845, -21846, 21845, -21846, 21845, -21846, 1'b0);
    queue_item(16384, -16384, -1, 0, 0, 0, 1'b1);

    run_phase(256, 65535, 150, 1'b1);
    run_phase(0, 0, 150, 1'b1);
    run_phase(511, 65535, 150, 1'b1);
    run_phase(257, 1, 100, 1'b1);
    run_phase(128, 30000, 150, 1'b1);
    run_phase($urandom_range(0, 256), $urandom_range(0, 65535), 150, 1'b1);
    run_phase($urandom_range(0, 511), $urandom_range(0, 65535), 100, 1'b1);
    run_phase(230, 5117, 150, 1'b0);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("imu_attitude_complementary_filter_unit_tb OK");
    end else begin
      $display("imu_attitude_complementary_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
